// ===== design/sorted_keyed_table_unit_assert.svh =====
// Assertion macros for the port-level checker of the sorted keyed table unit.
`ifndef SORTED_KEYED_TABLE_UNIT_ASSERT_SVH
`define SORTED_KEYED_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle while rst_n is low.
`define SKT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, idle while rst_n is low.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/skt_pkg.sv =====
// Types, codes and defaults shared by the sorted keyed table unit.
`timescale 1ns / 1ps
package skt_pkg;

  localparam int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_READ   = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BOUNDS    = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic               kind;
    logic signed [31:0] attribute;
  } entry_t;

  // Broadcast control seen by every cell in the chain.
  typedef struct packed {
    act_t       op;
    logic       ins_go;
    entry_t     new_ent;
    logic [7:0] rd_index;
  } ctl_t;

  typedef struct packed {
    status_t    status;
    logic [4:0] position;
    entry_t     ent;
    logic [4:0] entry_count;
  } res_t;

endpackage

// ===== design/skt_cell.sv =====
// One cell of the sorted table chain: holds one entry, compares and shifts.
`timescale 1ns / 1ps
module skt_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 5,
  parameter int POS_W    = 4
) (
  input  logic                clk,
  input  skt_pkg::ctl_t       ctl,
  input  logic [CNT_W-1:0]    cnt,
  input  skt_pkg::entry_t     left_ent,
  input  logic                left_mark,
  input  logic                left_seen,
  input  logic [POS_W-1:0]    left_pos,
  input  skt_pkg::entry_t     left_acc,
  output skt_pkg::entry_t     ent_out,
  output logic                mark_out,
  output logic                seen_out,
  output logic [POS_W-1:0]    pos_out,
  output skt_pkg::entry_t     acc_out
);

  skt_pkg::entry_t entry_r;
  skt_pkg::entry_t entry_nxt;
  logic occ;
  logic gt;
  logic match;
  logic hit;

  assign occ = CNT_W'(CELL_IDX) < cnt;
  assign gt  = occ && ($signed(entry_r.key) > $signed(ctl.new_ent.key));
  // The mark is set on every cell at or after the insert point.
  assign mark_out = gt || !occ;
  assign match    = occ && (entry_r.key == ctl.new_ent.key);
  assign seen_out = left_seen || match;

  always_comb begin
    hit = 1'b0;
    unique case (ctl.op)
      skt_pkg::ACT_INSERT: hit = mark_out && !left_mark;
      skt_pkg::ACT_FIND:   hit = match && !left_seen;
      skt_pkg::ACT_READ:   hit = ctl.rd_index == 8'(CELL_IDX);
      default:             hit = 1'b0;
    endcase
  end

  assign pos_out = left_pos | (hit ? POS_W'(CELL_IDX) : '0);
  assign acc_out = left_acc | (hit ? entry_r : '0);
  assign ent_out = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_go) begin
      if (left_mark) begin
        entry_nxt = left_ent;
      end else if (mark_out) begin
        entry_nxt = ctl.new_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== design/skt_out_buf.sv =====
// Two-deep result buffer: output register plus skid register.
`timescale 1ns / 1ps
module skt_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  skt_pkg::res_t push_res,
  input  logic          out_stall,
  output logic          out_valid,
  output skt_pkg::res_t out_res,
  output logic          full
);

  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  skt_pkg::res_t out_res_r, out_res_nxt;
  skt_pkg::res_t skid_res_r, skid_res_nxt;
  logic          take;

  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      if (take) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_res_nxt   = push_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign full      = skid_valid_r;

endmodule

// ===== design/sorted_keyed_table_unit.sv =====
// Top level of the sorted keyed table unit: cell chain, count and result buffer.
//
// The unit keeps up to CAPACITY entries (key, kind, attribute) sorted by
// ascending signed key, and answers three kinds of request: insert, find by
// key and read by index. Every accepted request gives exactly one result.
// A request is accepted in any cycle where in_valid is high and in_stall is
// low, and its result is registered in the output register, or in the skid
// register while a result waits; the unit takes one request per clock cycle
// while in_stall is low. That rate comes from the chain of cells: each cell
// holds one entry and compares it with the request key in the same cycle, and
// on an insert every cell past the insert point loads its left neighbor's
// entry, so the whole table shifts at once. The first match, the insert point
// and the read hit ripple along the chain within that cycle. Results pass
// through an output register and a skid register, so a request is still
// taken while one result waits on out_stall; in_stall rises only when both
// are occupied. An insert into a full table is dropped and reported as table
// full. Equal keys stay in arrival order, and a find returns the first entry
// with the key. A read of an empty table reports the empty status before any
// bounds check. The position and entry count fields are five bits wide and
// wrap for tables of more than 31 entries. Entries past the count are never
// read, so the table needs no clearing after reset.
`timescale 1ns / 1ps
module sorted_keyed_table_unit #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_key,
  input  logic               in_kind,
  input  logic signed [31:0] in_attribute,
  input  logic [7:0]         in_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [4:0]         out_position,
  output logic signed [31:0] out_found_key,
  output logic               out_found_kind,
  output logic signed [31:0] out_found_attribute,
  output logic [4:0]         out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  logic            accept;
  logic            full;
  logic            buf_full;
  logic [CNT_W-1:0] count_r, count_nxt;
  skt_pkg::act_t   op;
  skt_pkg::ctl_t   ctl;
  skt_pkg::res_t   res;
  skt_pkg::res_t   out_res;

  // Links between neighboring cells; slot zero is the tie-off at the head.
  skt_pkg::entry_t  ent_w  [0:CAPACITY];
  logic             mark_w [0:CAPACITY];
  logic             seen_w [0:CAPACITY];
  logic [POS_W-1:0] pos_w  [0:CAPACITY];
  skt_pkg::entry_t  acc_w  [0:CAPACITY];

  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;
  assign op       = skt_pkg::act_t'(in_action);
  assign full     = count_r == CNT_W'(CAPACITY);

  assign ctl.op            = op;
  assign ctl.ins_go        = accept && (op == skt_pkg::ACT_INSERT) && !full;
  assign ctl.new_ent.key       = in_key;
  assign ctl.new_ent.kind      = in_kind;
  assign ctl.new_ent.attribute = in_attribute;
  assign ctl.rd_index      = in_index;

  assign ent_w[0]  = '0;
  assign mark_w[0] = 1'b0;
  assign seen_w[0] = 1'b0;
  assign pos_w[0]  = '0;
  assign acc_w[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skt_cell #(
      .CELL_IDX (i),
      .CNT_W    (CNT_W),
      .POS_W    (POS_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cnt       (count_r),
      .left_ent  (ent_w[i]),
      .left_mark (mark_w[i]),
      .left_seen (seen_w[i]),
      .left_pos  (pos_w[i]),
      .left_acc  (acc_w[i]),
      .ent_out   (ent_w[i+1]),
      .mark_out  (mark_w[i+1]),
      .seen_out  (seen_w[i+1]),
      .pos_out   (pos_w[i+1]),
      .acc_out   (acc_w[i+1])
    );
  end

  assign count_nxt = ctl.ins_go ? count_r + CNT_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result of the request at the head of the input channel.
  always_comb begin
    res             = '0;
    res.status      = skt_pkg::ST_OK;
    res.entry_count = 5'(count_nxt);
    unique case (op)
      skt_pkg::ACT_INSERT: begin
        if (full) begin
          res.status = skt_pkg::ST_FULL;
        end else begin
          res.position = 5'(pos_w[CAPACITY]);
          res.ent      = ctl.new_ent;
        end
      end
      skt_pkg::ACT_FIND: begin
        if (seen_w[CAPACITY]) begin
          res.position = 5'(pos_w[CAPACITY]);
          res.ent      = acc_w[CAPACITY];
        end else begin
          res.status   = skt_pkg::ST_NOT_FOUND;
          res.position = 5'(count_r);
        end
      end
      skt_pkg::ACT_READ: begin
        if (count_r == '0) begin
          res.status = skt_pkg::ST_EMPTY;
        end else if (CMP_W'(in_index) >= CMP_W'(count_r)) begin
          res.status = skt_pkg::ST_BOUNDS;
        end else begin
          res.position = 5'(in_index);
          res.ent      = acc_w[CAPACITY];
        end
      end
      default: begin
        res.status = skt_pkg::ST_OK;
      end
    endcase
  end

  skt_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_res  (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (buf_full)
  );

  assign out_status          = out_res.status;
  assign out_position        = out_res.position;
  assign out_found_key       = out_res.ent.key;
  assign out_found_kind      = out_res.ent.kind;
  assign out_found_attribute = out_res.ent.attribute;
  assign out_entry_count     = out_res.entry_count;

endmodule

// ===== design/skt_checker.sv =====
// Port-level assertions for the sorted keyed table unit, bound to the top level.
`timescale 1ns / 1ps
`include "sorted_keyed_table_unit_assert.svh"
module skt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_status,
  input logic [4:0]         out_position,
  input logic signed [31:0] out_found_key,
  input logic               out_found_kind,
  input logic signed [31:0] out_found_attribute,
  input logic [4:0]         out_entry_count
);

  `SKT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_position) && $stable(out_found_key) && $stable(out_entry_count), "stalled result changed")

  `SKT_ASSERT_NOW(a_full_zero, out_valid && (out_status == skt_pkg::ST_FULL), (out_position == 5'd0) && (out_found_key == 32'sd0) && !out_found_kind && (out_found_attribute == 32'sd0), "dropped insert reported nonzero fields")

  `SKT_ASSERT_NOW(a_miss_pos, out_valid && (out_status == skt_pkg::ST_NOT_FOUND), out_position == out_entry_count, "missed find position differs from count")

  `SKT_ASSERT_NOW(a_empty_cnt, out_valid && (out_status == skt_pkg::ST_EMPTY), out_entry_count == 5'd0, "empty read with entries held")

endmodule

bind sorted_keyed_table_unit skt_checker u_skt_checker (.*);

// ===== tb/sv/skt_result_checker.sv =====
// Checker for the sorted keyed table unit: shadow table, owed results and field compare.
`timescale 1ns / 1ps
module skt_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_key,
  input  logic               in_kind,
  input  logic signed [31:0] in_attribute,
  input  logic [7:0]         in_index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_status,
  input  logic [4:0]         out_position,
  input  logic signed [31:0] out_found_key,
  input  logic               out_found_kind,
  input  logic signed [31:0] out_found_attribute,
  input  logic [4:0]         out_entry_count,
  output int                 fail_count,
  output int                 results_owed
);

  localparam int SHELF_SIZE = skt_pkg::CAPACITY_DEF;

  skt_pkg::entry_t shelf [SHELF_SIZE];
  int              shelf_count;
  skt_pkg::res_t   owed_results [$];

  // Applies one request to the shadow table and returns the result it should give.
  function automatic skt_pkg::res_t apply_request(logic [1:0] action,
                                                  skt_pkg::entry_t req,
                                                  logic [7:0] index);
    skt_pkg::res_t r;
    int            pos;
    r = '0;
    r.status = skt_pkg::ST_OK;
    case (action)
      skt_pkg::ACT_INSERT: begin
        if (shelf_count >= SHELF_SIZE) begin
          r.status = skt_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < shelf_count && !($signed(shelf[pos].key) > $signed(req.key))) pos++;
          for (int i = shelf_count; i > pos; i--) shelf[i] = shelf[i - 1];
          shelf[pos] = req;
          shelf_count++;
          r.position = 5'(pos);
          r.ent = req;
        end
      end
      skt_pkg::ACT_FIND: begin
        r.status = skt_pkg::ST_NOT_FOUND;
        r.position = 5'(shelf_count);
        for (int i = shelf_count - 1; i >= 0; i--) begin
          if (shelf[i].key == req.key) begin
            r.status = skt_pkg::ST_OK;
            r.position = 5'(i);
            r.ent = shelf[i];
          end
        end
      end
      skt_pkg::ACT_READ: begin
        if (shelf_count == 0) begin
          r.status = skt_pkg::ST_EMPTY;
        end else if (int'(index) >= shelf_count) begin
          r.status = skt_pkg::ST_BOUNDS;
        end else begin
          r.position = 5'(index);
          r.ent = shelf[index];
        end
      end
      default: begin
        // The spare action code leaves the table alone and answers with zeros but for the entry count.
      end
    endcase
    r.entry_count = 5'(shelf_count);
    return r;
  endfunction

  task automatic note_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    skt_pkg::res_t   want;
    skt_pkg::entry_t req;
    if (!rst_n) begin
      shelf_count = 0;
      owed_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: result with nothing owed, expected none, got status %0h",
                   $time, out_status);
        end else begin
          want = owed_results.pop_front();
          note_field("status", 32'(want.status), 32'(out_status));
          note_field("position", 32'(want.position), 32'(out_position));
          note_field("found_key", want.ent.key, out_found_key);
          note_field("found_kind", 32'(want.ent.kind), 32'(out_found_kind));
          note_field("found_attribute", want.ent.attribute, out_found_attribute);
          note_field("entry_count", 32'(want.entry_count), 32'(out_entry_count));
        end
      end
      if (in_valid && !in_stall) begin
        req.key = in_key;
        req.kind = in_kind;
        req.attribute = in_attribute;
        owed_results.push_back(apply_request(in_action, req, in_index));
      end
    end
    results_owed = owed_results.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the sorted keyed table unit testbench: clock, reset, requests, receiver and verdict.
`timescale 1ns / 1ps
module tb_top;

  // The spare action code, which the unit answers without touching the table.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1160;
  localparam int WATCHDOG_LIMIT = 600;
  // The long receiver hold-off that fills the unit and stalls its input.
  localparam int PRESSURE_AT = 300;
  localparam int PRESSURE_CYCLES = 64;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_action;
  logic signed [31:0] in_key;
  logic               in_kind;
  logic signed [31:0] in_attribute;
  logic [7:0]         in_index;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_status;
  logic [4:0]         out_position;
  logic signed [31:0] out_found_key;
  logic               out_found_kind;
  logic signed [31:0] out_found_attribute;
  logic [4:0]         out_entry_count;

  int fail_count;
  int results_owed;
  int requests_sent;
  bit pressure_on;

  // Keys that went into the table, kept so that finds can aim at real entries.
  logic signed [31:0] stored_keys [$];

  sorted_keyed_table_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_key              (in_key),
    .in_kind             (in_kind),
    .in_attribute        (in_attribute),
    .in_index            (in_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_position        (out_position),
    .out_found_key       (out_found_key),
    .out_found_kind      (out_found_kind),
    .out_found_attribute (out_found_attribute),
    .out_entry_count     (out_entry_count)
  );

  skt_result_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_key              (in_key),
    .in_kind             (in_kind),
    .in_attribute        (in_attribute),
    .in_index            (in_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_position        (out_position),
    .out_found_key       (out_found_key),
    .out_found_kind      (out_found_kind),
    .out_found_attribute (out_found_attribute),
    .out_entry_count     (out_entry_count),
    .fail_count          (fail_count),
    .results_owed        (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Keys lean on the extremes and on a narrow band around zero, so that
  // duplicates, ties in the sort order and find hits are common.
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3, 4, 5: return 32'($urandom_range(0, 10)) - 32'd5;
      default: return $urandom();
    endcase
  endfunction

  // Offers one request and returns at the edge where the unit takes it.
  // The gap before it is drawn per request; every third block of 64
  // requests goes back to back, and so does the sender while the receiver
  // is holding off, so that the unit fills and raises in_stall.
  task automatic send_request(logic [1:0] action, logic signed [31:0] key, logic kind,
                              logic signed [31:0] attribute, logic [7:0] index);
    int gap;
    gap = (pressure_on || (requests_sent / 64) % 3 == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_key <= key;
    in_kind <= kind;
    in_attribute <= attribute;
    in_index <= index;
    do @(posedge clk); while (in_stall);
    // An insert into a full table is dropped, so only the first CAPACITY count.
    if (action == skt_pkg::ACT_INSERT && stored_keys.size() < skt_pkg::CAPACITY_DEF) begin
      stored_keys.push_back(key);
    end
    requests_sent++;
  endtask

  initial begin
    int                 pick;
    int                 held;
    int                 insert_odds;
    logic [1:0]         action;
    logic signed [31:0] key;
    logic [7:0]         index;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = skt_pkg::ACT_INSERT;
    in_key = '0;
    in_kind = 1'b0;
    in_attribute = '0;
    in_index = '0;
    requests_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. An empty table first: reads report the empty status
    // whatever the index, and a find misses with position zero.
    send_request(skt_pkg::ACT_READ, 32'sd0, 1'b0, 32'sd0, 8'd0);
    send_request(skt_pkg::ACT_READ, 32'sd0, 1'b0, 32'sd0, 8'hff);
    send_request(skt_pkg::ACT_FIND, 32'sd0, 1'b0, 32'sd0, 8'd0);
    // The spare action code with every bit set must leave the table alone.
    send_request(ACT_UNUSED, -32'sd1, 1'b1, -32'sd1, 8'hff);
    // Extreme keys, then two equal keys that must keep their arrival order.
    send_request(skt_pkg::ACT_INSERT, 32'sh7fff_ffff, 1'b1, -32'sd1, 8'd0);
    send_request(skt_pkg::ACT_INSERT, 32'sh8000_0000, 1'b0, 32'sh8000_0000, 8'd0);
    send_request(skt_pkg::ACT_INSERT, 32'sd0, 1'b1, 32'sh7fff_ffff, 8'd0);
    send_request(skt_pkg::ACT_INSERT, 32'sd0, 1'b0, 32'sd0, 8'd0);
    // Finds: the first of the equal keys, both extremes, and a miss that
    // must report the entry count as its position.
    send_request(skt_pkg::ACT_FIND, 32'sd0, 1'b0, 32'sd0, 8'd0);
    send_request(skt_pkg::ACT_FIND, 32'sh8000_0000, 1'b0, 32'sd0, 8'd0);
    send_request(skt_pkg::ACT_FIND, 32'sh7fff_ffff, 1'b0, 32'sd0, 8'd0);
    send_request(skt_pkg::ACT_FIND, 32'sd5, 1'b0, 32'sd0, 8'd0);
    // Reads: first and last entry, exactly at the count, and far beyond it.
    send_request(skt_pkg::ACT_READ, 32'sd0, 1'b0, 32'sd0, 8'd0);
    send_request(skt_pkg::ACT_READ, 32'sd0, 1'b0, 32'sd0, 8'd3);
    send_request(skt_pkg::ACT_READ, 32'sd0, 1'b0, 32'sd0, 8'd4);
    send_request(skt_pkg::ACT_READ, 32'sd0, 1'b0, 32'sd0, 8'hff);
    send_request(ACT_UNUSED, 32'sd0, 1'b0, 32'sd0, 8'd0);

    // Random part. Inserts are rare while the table has room, so finds and
    // reads run against every fill level on the way up. Once it is full the
    // inserts come a little more often and must all be reported as dropped.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      held = stored_keys.size();
      insert_odds = (held < skt_pkg::CAPACITY_DEF) ? 5 : 10;
      pick = $urandom_range(0, 99);
      key = pick_key();
      if ($urandom_range(0, 3) == 0) index = 8'($urandom());
      else index = 8'($urandom_range(0, held + 1));
      if (pick < insert_odds) begin
        action = skt_pkg::ACT_INSERT;
      end else if (pick >= 97) begin
        action = ACT_UNUSED;
      end else if (pick < 55) begin
        action = skt_pkg::ACT_FIND;
        if (held > 0 && $urandom_range(0, 1) == 1) begin
          key = stored_keys[$urandom_range(0, held - 1)];
        end
      end else begin
        action = skt_pkg::ACT_READ;
      end
      send_request(action, key, 1'($urandom()), $urandom(), index);
    end
    in_valid <= 1'b0;

    // Drain: wait until every owed result is in, then keep the clock running to
    // catch any stray result that the unit might still put out.
    do @(negedge clk); while (results_owed != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver. After each result it draws how long to stall before the next
  // one, with every third block of 50 results taken without stalling. At one
  // point it holds off for a long stretch while the sender keeps pushing.
  initial begin
    int taken;
    int hold;
    out_stall = 1'b0;
    pressure_on = 1'b0;
    taken = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        taken++;
        if (taken == PRESSURE_AT) begin
          hold = PRESSURE_CYCLES;
          pressure_on = 1'b1;
        end else begin
          hold = ((taken / 50) % 3 == 1) ? 0 : $urandom_range(0, 17);
        end
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        pressure_on = 1'b0;
      end
    end
  end

  // Watchdog: too many cycles in a row without a request or a result taken
  // means the unit has hung.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
+incdir+design
design/skt_pkg.sv
design/skt_cell.sv
design/skt_out_buf.sv
design/sorted_keyed_table_unit.sv
design/skt_checker.sv
tb/sv/skt_result_checker.sv
tb/sv/tb_top.sv
